// ----- sv/fir_pkg.sv -----
// shared widths, codes and beat types for the q16 fir filter
`default_nettype none

package fir_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int COEF_SHIFT = 16;
    localparam int SUM_W      = 16;
    localparam int TAPIDX_W   = 4;
    localparam int TAPCNT_W   = 5;
    localparam int SP_W       = 13;
    localparam int PAD_W      = 12;
    localparam int DIM_W      = 13;
    localparam int FILL_W     = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic CMD_LOAD_TAP = 1'b0;
    localparam logic CMD_SAMPLE   = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_COUNT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_SPACING = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_PAD     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_COUNT   = 3'd4;

    typedef struct packed {
        logic                cmd;
        logic [TAPIDX_W-1:0] tap_index;
        logic [COEF_W-1:0]   coefficient;
        logic [PIX_W-1:0]    sample;
        logic                first;
    } fir_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] result;
        logic             last_output;
    } fir_out_t;

    typedef struct packed {
        logic start;
        logic valid;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- sv/fir_filter_u8_q16_saturating.sv -----
// top level: history memory, kernel memory, tap sequencer and output register
// a sample beat that yields a pixel passes setup, check, tap walk and drain, then is put in the
// output register in deliver; depths below 8192 also pass reduce to take the spacing modulo depth
// the history memory port takes one read per tap, so the block takes no new sample until it is
// back in idle after the last one, and it takes a kernel load beat every cycle while idle
// reset sets config to defaults, clears counters, write pointer and kernel valid bits, not history
`default_nettype none

module fir_filter_u8_q16_saturating #(
    parameter int MAX_TAPS      = 16,
    parameter int HISTORY_DEPTH = 65536
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pix_valid,
    output logic                               pix_ready,
    input  wire fir_pkg::fir_in_t              pix_data,
    output logic                               flt_valid,
    input  wire logic                          flt_ready,
    output fir_pkg::fir_out_t                  flt_data,
    input  wire logic                          cfg_we,
    input  wire logic [fir_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [fir_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int HW        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int KW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int SP_W      = fir_pkg::SP_W;
    localparam int DIV_W     = SP_W + 1;
    localparam int RED_STEPS = (HISTORY_DEPTH >= (1 << SP_W)) ? 0 : DIV_W - HW;
    localparam int RKW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int CW        = ((HW > SP_W) ? HW : SP_W) + 1;
    localparam int COL_W     = fir_pkg::DIM_W + 1;
    localparam int DLY_W     = fir_pkg::FILL_W + 1;
    localparam logic [HW-1:0] WP_LAST = HW'(HISTORY_DEPTH - 1);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SETUP   = 7'b0000010,
        ST_REDUCE  = 7'b0000100,
        ST_CHECK   = 7'b0001000,
        ST_WALK    = 7'b0010000,
        ST_DRAIN   = 7'b0100000,
        ST_DELIVER = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [fir_pkg::TAPCNT_W-1:0] tap_count_reg;
    logic [SP_W-1:0]              tap_spacing_reg;
    logic [fir_pkg::DIM_W-1:0]    row_width_reg;
    logic [fir_pkg::PAD_W-1:0]    row_pad_reg;
    logic [fir_pkg::DIM_W-1:0]    row_count_reg;

    // image position
    logic [HW-1:0]               wp_reg;
    logic [HW-1:0]               wp_next;
    logic [fir_pkg::FILL_W-1:0]  fill_reg;
    logic [fir_pkg::FILL_W-1:0]  fill_base;
    logic [fir_pkg::FILL_W-1:0]  fill_next;
    logic                        filled;
    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_base;
    logic [COL_W-1:0]            col_step;
    logic [COL_W-1:0]            col_next;
    logic [COL_W-1:0]            stride;
    logic [fir_pkg::DIM_W-1:0]   row_reg;
    logic [fir_pkg::DIM_W-1:0]   row_base;
    logic [fir_pkg::DIM_W-1:0]   row_next;
    logic                        col_wrap;
    logic                        emit_ok;
    logic                        is_last;
    logic [fir_pkg::TAPCNT_W-1:0] tap_sel;

    // per-sample work registers
    logic [HW-1:0]                newest_reg;
    logic [fir_pkg::TAPCNT_W-1:0] taps_reg;
    logic                         emit_reg;
    logic                         last_reg;
    logic [DLY_W-1:0]             delay_reg;
    logic [DLY_W-1:0]             delay_calc;
    logic [SP_W-1:0]              sp_reg;
    logic [RKW-1:0]               red_k_reg;
    logic [DIV_W-1:0]             red_div;
    logic [DIV_W-1:0]             red_diff;
    logic [HW-1:0]                addr_reg;
    logic [CW-1:0]                addr_diff;
    logic [HW-1:0]                addr_step;
    logic [fir_pkg::TAPCNT_W-1:0] t_reg;
    logic                         walk_go;

    // beats
    logic accept;
    logic take_sample;
    logic kern_we;
    logic load_out;

    // memories
    logic [fir_pkg::PIX_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic [fir_pkg::COEF_W-1:0] kern_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]        kern_vld_reg;
    logic [fir_pkg::PIX_W-1:0]  hist_q;
    logic [fir_pkg::COEF_W-1:0] kern_q;
    logic                       kern_vq;
    logic [31:0]                kidx_w32;
    logic [31:0]                kidx_r32;
    logic [KW-1:0]              kidx_w;
    logic [KW-1:0]              kidx_r;
    logic                       rd_v_reg;
    logic                       rd_last_reg;

    // mac
    fir_pkg::mac_ctl_t          mac_ctl;
    logic                       mac_done;
    logic [fir_pkg::PIX_W-1:0]  mac_sum;
    logic                       flt_valid_reg;
    fir_pkg::fir_out_t          flt_data_reg;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg   <= fir_pkg::TAPCNT_W'(1);
            tap_spacing_reg <= SP_W'(1);
            row_width_reg   <= fir_pkg::DIM_W'(1);
            row_pad_reg     <= '0;
            row_count_reg   <= fir_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fir_pkg::CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[fir_pkg::TAPCNT_W-1:0];
                fir_pkg::CFG_TAP_SPACING: tap_spacing_reg <= cfg_data[SP_W-1:0];
                fir_pkg::CFG_ROW_WIDTH:   row_width_reg   <= cfg_data[fir_pkg::DIM_W-1:0];
                fir_pkg::CFG_ROW_PAD:     row_pad_reg     <= cfg_data[fir_pkg::PAD_W-1:0];
                fir_pkg::CFG_ROW_COUNT:   row_count_reg   <= cfg_data[fir_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input beat
    assign pix_ready   = (state_reg == ST_IDLE);
    assign accept      = pix_valid && pix_ready;
    assign take_sample = accept && (pix_data.cmd == fir_pkg::CMD_SAMPLE);
    assign kidx_w32    = 32'(pix_data.tap_index);
    assign kidx_w      = kidx_w32[KW-1:0];
    assign kern_we     = accept && (pix_data.cmd == fir_pkg::CMD_LOAD_TAP)
                         && (kidx_w32 < 32'(MAX_TAPS));

    // first sample restarts the image position before this sample counts
    assign fill_base = pix_data.first ? '0 : fill_reg;
    assign col_base  = pix_data.first ? '0 : col_reg;
    assign row_base  = pix_data.first ? '0 : row_reg;
    assign fill_next = (fill_base != '1) ? fill_base + 1'b1 : fill_base;
    assign wp_next   = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
    assign filled    = (DLY_W'(fill_next) > delay_calc);

    assign emit_ok  = (col_base < COL_W'(row_width_reg)) && (row_base < row_count_reg);
    assign is_last  = (COL_W'(row_base) + 1'b1 == COL_W'(row_count_reg))
                      && (col_base + 1'b1 == COL_W'(row_width_reg));
    assign stride   = COL_W'(row_width_reg) + COL_W'(row_pad_reg);
    assign col_step = col_base + 1'b1;
    assign col_wrap = (col_step >= stride);
    assign col_next = col_wrap ? '0 : col_step;
    assign row_next = (col_wrap && (row_base != '1)) ? row_base + 1'b1 : row_base;

    assign tap_sel = (tap_count_reg == '0) ? fir_pkg::TAPCNT_W'(1) :
                     (32'(tap_count_reg) > 32'(MAX_TAPS)) ? fir_pkg::TAPCNT_W'(MAX_TAPS) :
                     tap_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else if (take_sample)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
            // output position only moves once the taps span stored samples
            col_reg  <= filled ? col_next : col_base;
            row_reg  <= filled ? row_next : row_base;
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign delay_calc = DLY_W'(tap_sel - 1'b1) * DLY_W'(tap_spacing_reg);
    assign red_div    = DIV_W'(HISTORY_DEPTH) << red_k_reg;
    assign red_diff   = DIV_W'(sp_reg) - red_div;
    assign walk_go    = emit_reg && (DLY_W'(fill_reg) > delay_reg);

    // step one tap back, modulo the history depth
    assign addr_diff = CW'(addr_reg) - CW'(sp_reg);
    assign addr_step = addr_diff[CW-1] ? HW'(addr_diff + CW'(HISTORY_DEPTH)) : HW'(addr_diff);

    assign load_out = (state_reg == ST_DELIVER) && (!flt_valid_reg || flt_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = (RED_STEPS > 0) ? ST_REDUCE : ST_CHECK;
            end
            ST_REDUCE:
            begin
                if (red_k_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = walk_go ? ST_WALK : ST_IDLE;
            end
            ST_WALK:
            begin
                if (t_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_v_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_v_reg    <= (state_reg == ST_WALK);
            rd_last_reg <= (state_reg == ST_WALK) && (t_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            newest_reg <= wp_reg;
            taps_reg   <= tap_sel;
            emit_reg   <= emit_ok;
            last_reg   <= is_last;
        end
        if (state_reg == ST_SETUP)
        begin
            delay_reg <= delay_calc;
            sp_reg    <= tap_spacing_reg;
            red_k_reg <= RKW'(RED_STEPS - 1);
        end
        // restoring reduction of the spacing modulo the depth
        if (state_reg == ST_REDUCE)
        begin
            if (DIV_W'(sp_reg) >= red_div)
            begin
                sp_reg <= SP_W'(red_diff);
            end
            red_k_reg <= red_k_reg - 1'b1;
        end
        if (state_reg == ST_CHECK)
        begin
            addr_reg <= newest_reg;
            t_reg    <= taps_reg - 1'b1;
        end
        if (state_reg == ST_WALK)
        begin
            addr_reg <= addr_step;
            t_reg    <= t_reg - 1'b1;
        end
    end

    // ---------------------------------------------------------------- memories
    assign kidx_r32 = 32'(t_reg);
    assign kidx_r   = kidx_r32[KW-1:0];

    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            hist_mem[wp_reg] <= pix_data.sample;
        end
        if (state_reg == ST_WALK)
        begin
            hist_q <= hist_mem[addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (kern_we)
        begin
            kern_mem[kidx_w] <= pix_data.coefficient;
        end
        if (state_reg == ST_WALK)
        begin
            kern_q  <= kern_mem[kidx_r];
            kern_vq <= kern_vld_reg[kidx_r];
        end
    end

    // an unloaded tap reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kern_vld_reg <= '0;
        end
        else if (kern_we)
        begin
            kern_vld_reg[kidx_w] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- mac
    assign mac_ctl.start = (state_reg == ST_CHECK);
    assign mac_ctl.valid = rd_v_reg;
    assign mac_ctl.last  = rd_last_reg;

    fir_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .pixel (hist_q),
        .coef  (kern_vq ? kern_q : '0),
        .done  (mac_done),
        .sum8  (mac_sum)
    );

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flt_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            flt_valid_reg <= 1'b1;
        end
        else if (flt_ready)
        begin
            flt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            flt_data_reg.result      <= mac_sum;
            flt_data_reg.last_output <= last_reg;
        end
    end

    assign flt_valid = flt_valid_reg;
    assign flt_data  = flt_data_reg;

endmodule

`default_nettype wire

// ----- sv/fir_mac.sv -----
// multiply, q16 truncate and saturating accumulate for one output pixel
`default_nettype none

module fir_mac (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fir_pkg::mac_ctl_t         ctl,
    input  wire logic [fir_pkg::PIX_W-1:0]  pixel,
    input  wire logic [fir_pkg::COEF_W-1:0] coef,
    output logic                           done,
    output logic [fir_pkg::PIX_W-1:0]       sum8
);

    localparam int PROD_W = fir_pkg::PIX_W + fir_pkg::COEF_W;
    localparam int TERM_W = PROD_W - fir_pkg::COEF_SHIFT;
    localparam logic [fir_pkg::SUM_W-1:0] PIX_MAX = fir_pkg::SUM_W'((1 << fir_pkg::PIX_W) - 1);

    logic [PROD_W-1:0]         prod;
    logic [TERM_W-1:0]         term_reg;
    logic                      term_v_reg;
    logic                      term_last_reg;
    logic                      done_reg;
    logic [fir_pkg::SUM_W-1:0] acc_reg;
    logic [fir_pkg::SUM_W:0]   acc_sum;
    logic [fir_pkg::SUM_W-1:0] acc_next;

    assign prod     = PROD_W'(pixel) * PROD_W'(coef);
    assign acc_sum  = {1'b0, acc_reg} + (fir_pkg::SUM_W + 1)'(term_reg);
    assign acc_next = acc_sum[fir_pkg::SUM_W] ? '1 : acc_sum[fir_pkg::SUM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_v_reg    <= 1'b0;
            term_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            term_v_reg    <= ctl.valid;
            term_last_reg <= ctl.valid && ctl.last;
            done_reg      <= term_v_reg && term_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= prod[PROD_W-1:fir_pkg::COEF_SHIFT];
        if (ctl.start)
        begin
            acc_reg <= '0;
        end
        else if (term_v_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // accumulator holds after the last term until the next start
    assign done = done_reg;
    assign sum8 = (acc_reg > PIX_MAX) ? '1 : acc_reg[fir_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

// ----- sv/fir_chk.sv -----
// port-level checks for the q16 fir filter and their bind
`default_nettype none

module fir_chk (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pix_valid,
    input wire logic              pix_ready,
    input wire fir_pkg::fir_in_t  pix_data,
    input wire logic              flt_valid,
    input wire logic              flt_ready,
    input wire fir_pkg::fir_out_t flt_data
);

    // a sample beat starts tap work, so the input side closes
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready && pix_data.cmd == fir_pkg::CMD_SAMPLE) |=> !pix_ready)
        else $error("input still ready after a sample beat");

    // a kernel load finishes in its own cycle
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready && pix_data.cmd == fir_pkg::CMD_LOAD_TAP) |=> pix_ready)
        else $error("input not ready after a kernel load beat");

    // a new pixel never shows up in the cycle right after an input beat
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flt_valid) |-> !$past(pix_valid && pix_ready))
        else $error("output beat appeared directly after an input beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (flt_valid && !flt_ready) |=> (flt_valid && $stable(flt_data)))
        else $error("stalled output beat changed");

endmodule

bind fir_filter_u8_q16_saturating fir_chk u_fir_chk (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for the q16 fir filter: directed and random pixel streams checked beat by beat
`timescale 1ns / 100ps

module tb_top;

    localparam int NUM_TAPS    = 16;
    localparam int HIST_DEPTH  = 65536;
    localparam int SETTLE      = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int FILL_MAX    = (1 << fir_pkg::FILL_W) - 1;
    localparam int ROW_MAX     = (1 << fir_pkg::DIM_W) - 1;
    localparam int SUM_MAX     = (1 << fir_pkg::SUM_W) - 1;
    localparam int PIX_MAX     = (1 << fir_pkg::PIX_W) - 1;
    localparam int REPORT_MAX  = 200;

    logic                           clk;
    logic                           rst_n;
    logic                           pix_valid;
    logic                           pix_ready;
    fir_pkg::fir_in_t               pix_data;
    logic                           flt_valid;
    logic                           flt_ready;
    fir_pkg::fir_out_t              flt_data;
    logic                           cfg_we;
    logic [fir_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [fir_pkg::CFG_DATA_W-1:0] cfg_data;

    // filter state as the block should hold it
    logic [fir_pkg::PIX_W-1:0]  hist_mem [HIST_DEPTH];
    logic [fir_pkg::COEF_W-1:0] kernel_mem [NUM_TAPS];
    logic [15:0]       wr_ptr;
    int                fill_cnt;
    int                out_col;
    int                out_row;
    int                taps_reg;
    int                spacing_reg;
    int                width_reg;
    int                pad_reg;
    int                rows_reg;

    fir_pkg::fir_out_t expected_pixels [$];
    int       errors;
    int       src_idle_pct;
    int       sink_idle_pct;
    int       quiet_cycles;

    fir_filter_u8_q16_saturating #(
        .MAX_TAPS      (NUM_TAPS),
        .HISTORY_DEPTH (HIST_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .flt_valid (flt_valid),
        .flt_ready (flt_ready),
        .flt_data  (flt_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // advances the filter state by one beat and forms the pixel it yields, if any
    function automatic bit predict_pixel(input fir_pkg::fir_in_t beat,
                                         output fir_pkg::fir_out_t pix);
        int          taps;
        int          delay;
        int          back;
        int          sum;
        logic [15:0] newest;
        logic [15:0] addr;
        pix = '0;
        if (beat.cmd == fir_pkg::CMD_LOAD_TAP) begin
            kernel_mem[beat.tap_index] = beat.coefficient;
            return 1'b0;
        end
        if (beat.first) begin
            fill_cnt = 0;
            out_col  = 0;
            out_row  = 0;
        end
        newest = wr_ptr;
        hist_mem[newest] = beat.sample;
        wr_ptr = wr_ptr + 16'd1;
        if (fill_cnt < FILL_MAX)
            fill_cnt++;
        taps  = (taps_reg == 0) ? 1 : ((taps_reg > NUM_TAPS) ? NUM_TAPS : taps_reg);
        delay = (taps - 1) * spacing_reg;
        if (fill_cnt <= delay)
            return 1'b0;
        predict_pixel = 1'b0;
        if (out_col < width_reg && out_row < rows_reg) begin
            sum = 0;
            for (int t = 0; t < taps; t++) begin
                back = ((taps - 1 - t) * spacing_reg) % HIST_DEPTH;
                addr = newest - back[15:0];
                sum += (int'(hist_mem[addr]) * int'(kernel_mem[t])) >> fir_pkg::COEF_SHIFT;
                if (sum > SUM_MAX)
                    sum = SUM_MAX;
            end
            pix.result      = (sum > PIX_MAX) ? fir_pkg::PIX_W'(PIX_MAX)
                                              : sum[fir_pkg::PIX_W-1:0];
            pix.last_output = (out_row + 1 == rows_reg) && (out_col + 1 == width_reg);
            predict_pixel   = 1'b1;
        end
        if (out_col + 1 >= width_reg + pad_reg) begin
            out_col = 0;
            if (out_row < ROW_MAX)
                out_row++;
        end
        else begin
            out_col++;
        end
    endfunction

    function automatic logic [fir_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return fir_pkg::PIX_W'(PIX_MAX);
            default: return fir_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [fir_pkg::COEF_W-1:0] rand_coef();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return fir_pkg::COEF_W'($urandom);
        endcase
    endfunction

    function automatic fir_pkg::fir_in_t pixel_beat(input logic first,
                                                    input logic [fir_pkg::PIX_W-1:0] value);
        fir_pkg::fir_in_t b;
        b.cmd         = fir_pkg::CMD_SAMPLE;
        b.tap_index   = fir_pkg::TAPIDX_W'($urandom);
        b.coefficient = fir_pkg::COEF_W'($urandom);
        b.sample      = value;
        b.first       = first;
        return b;
    endfunction

    // first and sample are don't-cares on a tap load, so they get noise
    function automatic fir_pkg::fir_in_t tap_beat(input int idx,
                                                  input logic [fir_pkg::COEF_W-1:0] coef);
        fir_pkg::fir_in_t b;
        b.cmd         = fir_pkg::CMD_LOAD_TAP;
        b.tap_index   = idx[fir_pkg::TAPIDX_W-1:0];
        b.coefficient = coef;
        b.sample      = fir_pkg::PIX_W'($urandom);
        b.first       = 1'($urandom);
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < REPORT_MAX)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // valid stays high past the accepting edge; drain_filter or an idle gap lowers it
    task automatic send_beat(input fir_pkg::fir_in_t beat);
        fir_pkg::fir_out_t pix;
        if ($urandom_range(99) < src_idle_pct) begin
            pix_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        do @(posedge clk); while (!pix_ready);
        if (predict_pixel(beat, pix))
            expected_pixels.push_back(pix);
    endtask

    task automatic feed_pixels(input int count, input bit with_first);
        for (int i = 0; i < count; i++)
            send_beat(pixel_beat(with_first && i == 0, rand_pixel()));
    endtask

    task automatic load_taps(input int count);
        for (int t = 0; t < count; t++)
            send_beat(tap_beat(t, rand_coef()));
    endtask

    // sample beats that yield nothing may still be in flight when the queue empties
    task automatic drain_filter();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_geometry(input int taps, input int spacing, input int width,
                                input int pad, input int rows);
        drain_filter();
        cfg_we   <= 1'b1;
        cfg_addr <= fir_pkg::CFG_TAP_COUNT;
        cfg_data <= taps[fir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr <= fir_pkg::CFG_TAP_SPACING;
        cfg_data <= spacing[fir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr <= fir_pkg::CFG_ROW_WIDTH;
        cfg_data <= width[fir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr <= fir_pkg::CFG_ROW_PAD;
        cfg_data <= pad[fir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_addr <= fir_pkg::CFG_ROW_COUNT;
        cfg_data <= rows[fir_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        taps_reg    = taps & ((1 << fir_pkg::TAPCNT_W) - 1);
        spacing_reg = spacing & ((1 << fir_pkg::SP_W) - 1);
        width_reg   = width & ((1 << fir_pkg::DIM_W) - 1);
        pad_reg     = pad & ((1 << fir_pkg::PAD_W) - 1);
        rows_reg    = rows & ((1 << fir_pkg::DIM_W) - 1);
    endtask

    // kernel is all zero and geometry is 1x1 out of reset
    task automatic test_reset_defaults();
        send_beat(pixel_beat(1'b1, 8'd255));
        send_beat(pixel_beat(1'b0, 8'd0));
        send_beat(pixel_beat(1'b0, 8'd128));
    endtask

    task automatic test_kernel_extremes();
        logic [fir_pkg::PIX_W-1:0] pattern [10];
        pattern = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd1, 8'd255, 8'd255, 8'd0, 8'd0};
        set_geometry(3, 1, 4, 1, 2);
        send_beat(tap_beat(0, 16'hffff));
        send_beat(tap_beat(1, 16'h8000));
        send_beat(tap_beat(2, 16'h0001));
        send_beat(tap_beat(15, 16'hffff));
        for (int i = 0; i < 10; i++)
            send_beat(pixel_beat(i == 0, pattern[i]));
        // restart mid-image
        send_beat(pixel_beat(1'b1, 8'd255));
        send_beat(pixel_beat(1'b0, 8'd255));
        send_beat(pixel_beat(1'b0, 8'd255));
        send_beat(pixel_beat(1'b0, 8'd10));
    endtask

    task automatic test_tap_edge_cases();
        set_geometry(0, 1, 3, 0, 2);
        load_taps(1);
        feed_pixels(6, 1'b1);
        set_geometry(31, 1, 8, 0, 1);
        load_taps(NUM_TAPS);
        feed_pixels(24, 1'b1);
        // zero spacing: every tap sees the newest sample
        set_geometry(4, 0, 4, 0, 2);
        feed_pixels(10, 1'b1);
    endtask

    task automatic test_zero_geometry();
        set_geometry(2, 1, 0, 3, 4);
        feed_pixels(10, 1'b1);
        set_geometry(2, 1, 3, 1, 0);
        feed_pixels(10, 1'b1);
        set_geometry(1, 1, 0, 0, 3);
        feed_pixels(6, 1'b1);
        // same image carries on under a new geometry
        set_geometry(1, 1, 2, 0, 8);
        feed_pixels(6, 1'b0);
    endtask

    task automatic test_vertical();
        set_geometry(3, 7, 5, 2, 4);
        load_taps(3);
        feed_pixels(45, 1'b1);
    endtask

    task automatic test_random_images(input int count);
        int   sent;
        int   pick;
        int   taps;
        int   eff_taps;
        int   spacing;
        int   width;
        int   pad;
        int   rows;
        int   len;
        int   noise;
        logic first;
        sent = 0;
        while (sent < count) begin
            pick    = $urandom_range(9);
            width   = $urandom_range(1, 8);
            pad     = $urandom_range(0, 4);
            rows    = $urandom_range(1, 4);
            taps    = $urandom_range(1, NUM_TAPS);
            spacing = $urandom_range(1, 3);
            if (pick == 0)
                taps = $urandom_range(1) ? 0 : $urandom_range(NUM_TAPS + 1, 31);
            else if (pick < 4) begin
                taps    = $urandom_range(1, 4);
                spacing = width + pad;
            end
            else if (pick == 4)
                spacing = 0;
            set_geometry(taps, spacing, width, pad, rows);
            repeat ($urandom_range(0, 6)) begin
                send_beat(tap_beat($urandom_range(NUM_TAPS - 1), rand_coef()));
                sent++;
            end
            eff_taps = (taps == 0) ? 1 : ((taps > NUM_TAPS) ? NUM_TAPS : taps);
            len = (eff_taps - 1) * spacing + (width + pad) * rows + $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
                first = (i == 0) && ($urandom_range(4) != 0);
                noise = $urandom_range(49);
                if (noise == 0) begin
                    send_beat(tap_beat($urandom_range(NUM_TAPS - 1), rand_coef()));
                    sent++;
                end
                else if (noise == 1)
                    first = 1'b1;
                send_beat(pixel_beat(first, rand_pixel()));
                sent++;
            end
        end
    endtask

    task automatic test_large_geometry();
        set_geometry(1, 4096, 4096, 4095, 4096);
        send_beat(tap_beat(0, 16'hffff));
        feed_pixels(40, 1'b1);
    endtask

    initial begin
        fir_pkg::fir_out_t want;
        flt_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && flt_valid && flt_ready) begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected beat", int'(flt_data.result), -1);
                else begin
                    want = expected_pixels.pop_front();
                    if (flt_data.result !== want.result)
                        report_mismatch("result", int'(flt_data.result), int'(want.result));
                    if (flt_data.last_output !== want.last_output)
                        report_mismatch("last_output", int'(flt_data.last_output),
                                        int'(want.last_output));
                end
            end
            flt_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial quiet_cycles = 0;
    always @(posedge clk) begin
        if ((pix_valid && pix_ready) || (flt_valid && flt_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL fir_filter_u8_q16_saturating");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        errors        = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int t = 0; t < NUM_TAPS; t++)
            kernel_mem[t] = '0;
        wr_ptr      = '0;
        fill_cnt    = 0;
        out_col     = 0;
        out_row     = 0;
        taps_reg    = 1;
        spacing_reg = 1;
        width_reg   = 1;
        pad_reg     = 0;
        rows_reg    = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 12;
        sink_idle_pct = 51;
        test_reset_defaults();
        test_kernel_extremes();
        test_tap_edge_cases();
        test_zero_geometry();
        test_random_images(500);

        src_idle_pct  = 51;
        sink_idle_pct = 12;
        test_vertical();
        test_random_images(500);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_images(350);
        test_large_geometry();

        drain_filter();
        if (errors == 0)
            $display("PASS fir_filter_u8_q16_saturating");
        else
            $display("FAIL fir_filter_u8_q16_saturating");
        $finish;
    end

endmodule
